### rtl/stuffed_frame_encoder_core_macros.svh
// Assertion macros shared by the framer RTL.
`ifndef STUFFED_FRAME_ENCODER_CORE_MACROS_SVH
`define STUFFED_FRAME_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define SFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define SFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sfe_pkg.sv
// Package: types, constants and helpers of the stuffed frame encoder.
`timescale 1ns / 1ps
package sfe_pkg;

	localparam int BYTE_W      = 8;
	localparam int MAX_RESULTS = 9;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int SEQ_SHIFT   = 7;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// register indexes of the configuration port
	localparam cfg_idx_t CFG_FLAG    = 2'd0;
	localparam cfg_idx_t CFG_ESCAPE  = 2'd1;
	localparam cfg_idx_t CFG_MASK    = 2'd2;
	localparam cfg_idx_t CFG_ADDRESS = 2'd3;

	localparam byte_t FLAG_RST    = 8'd126;
	localparam byte_t ESCAPE_RST  = 8'd125;
	localparam byte_t MASK_RST    = 8'd95;
	localparam byte_t ADDRESS_RST = 8'd3;

	function automatic logic needs_stuff(byte_t b, byte_t flag, byte_t esc);
		return (b == flag) || (b == esc);
	endfunction

endpackage

### rtl/stuffed_frame_encoder_core.sv
// Top level: byte-stuffing information frame encoder.
`timescale 1ns / 1ps
`include "stuffed_frame_encoder_core_macros.svh"
// Usage
//   Input channel (in_valid / in_stall): one payload byte per transaction, with
//   sequence_bit, payload_start and payload_end. The first byte of a payload
//   (payload_start) is preceded by flag, address, control and header check;
//   the last byte (payload_end) is followed by the stuffed block check and a
//   closing flag. Bytes equal to flag or escape go out as escape, byte & mask.
//   Output channel (out_valid / out_stall): one frame byte per transaction;
//   run_last marks the final byte caused by an input transaction, frame_done
//   marks the closing flag.
//   Configuration: cfg_we / cfg_index / cfg_data, written only while idle.
// Timing
//   An accepted item is expanded combinationally into a list of 1 to 9 bytes
//   and held in the item register; its bytes then move one at a time into the
//   output register, one byte per cycle while the receiver does not stall, so
//   an item holds the block until all its bytes have moved out (1 or 2 for a
//   plain payload byte, up to 9 for a one-byte frame). The next item is accepted
//   in the cycle its predecessor's last byte moves out: no gaps on the output.
// Reset clears the valid flags, the block check and loads default registers.
// A stalled receiver holds the output register, and through it the item
// register; in_stall then stays high until the last byte is taken.
module stuffed_frame_encoder_core (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_we,
	input  sfe_pkg::cfg_idx_t       cfg_index,
	input  sfe_pkg::byte_t          cfg_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  sfe_pkg::byte_t          data_byte,
	input  logic                    sequence_bit,
	input  logic                    payload_start,
	input  logic                    payload_end,
	// output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output sfe_pkg::byte_t          frame_byte,
	output logic                    run_last,
	output logic                    frame_done
);

	// configuration registers
	sfe_pkg::byte_t flag_q, escape_q, mask_q, address_q;
	// running block check over the payload
	sfe_pkg::byte_t block_check_q;

	// item register: expanded byte list of the current transaction
	sfe_pkg::byte_t lst_s1 [sfe_pkg::MAX_RESULTS];
	sfe_pkg::cnt_t  cnt_s1;
	logic           end_s1;
	logic           valid_s1;
	sfe_pkg::cnt_t  idx_q;

	// expansion logic
	sfe_pkg::byte_t lst_c [sfe_pkg::MAX_RESULTS];
	sfe_pkg::cnt_t  pos_c;
	sfe_pkg::byte_t ctrl_c;
	sfe_pkg::byte_t check_c;
	sfe_pkg::byte_t bc_next_c;

	logic out_free, adv, last_s1, in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= sfe_pkg::FLAG_RST;
			escape_q  <= sfe_pkg::ESCAPE_RST;
			mask_q    <= sfe_pkg::MASK_RST;
			address_q <= sfe_pkg::ADDRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfe_pkg::CFG_FLAG:    flag_q    <= cfg_data;
				sfe_pkg::CFG_ESCAPE:  escape_q  <= cfg_data;
				sfe_pkg::CFG_MASK:    mask_q    <= cfg_data;
				sfe_pkg::CFG_ADDRESS: address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte list: header on start, stuffed data, stuffed check and closing flag on end.
	always_comb begin
		for (int i = 0; i < sfe_pkg::MAX_RESULTS; i++) begin
			lst_c[i] = '0;
		end
		pos_c  = '0;
		ctrl_c = sfe_pkg::byte_t'(sequence_bit) << sfe_pkg::SEQ_SHIFT;
		// a start clears the check before the byte is folded in
		bc_next_c = payload_start ? data_byte : (block_check_q ^ data_byte);
		check_c   = bc_next_c;

		if (payload_start) begin
			lst_c[0] = flag_q;
			lst_c[1] = address_q;
			lst_c[2] = ctrl_c;
			lst_c[3] = address_q ^ ctrl_c;
			pos_c    = sfe_pkg::cnt_t'(4);
		end

		if (sfe_pkg::needs_stuff(data_byte, flag_q, escape_q)) begin
			lst_c[pos_c]                     = escape_q;
			lst_c[pos_c + sfe_pkg::cnt_t'(1)] = data_byte & mask_q;
			pos_c                            = pos_c + sfe_pkg::cnt_t'(2);
		end else begin
			lst_c[pos_c] = data_byte;
			pos_c        = pos_c + sfe_pkg::cnt_t'(1);
		end

		if (payload_end) begin
			if (sfe_pkg::needs_stuff(check_c, flag_q, escape_q)) begin
				lst_c[pos_c]                     = escape_q;
				lst_c[pos_c + sfe_pkg::cnt_t'(1)] = check_c & mask_q;
				pos_c                            = pos_c + sfe_pkg::cnt_t'(2);
			end else begin
				lst_c[pos_c] = check_c;
				pos_c        = pos_c + sfe_pkg::cnt_t'(1);
			end
			lst_c[pos_c] = flag_q;
			pos_c        = pos_c + sfe_pkg::cnt_t'(1);
		end
	end

	// handshake
	assign out_free = !out_valid || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign last_s1  = (idx_q == (cnt_s1 - sfe_pkg::cnt_t'(1)));
	assign in_stall = valid_s1 && !(adv && last_s1);
	assign in_acc   = in_valid && !in_stall;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			idx_q         <= '0;
			block_check_q <= '0;
			out_valid     <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1      <= 1'b1;
				idx_q         <= '0;
				block_check_q <= payload_end ? '0 : bc_next_c;
			end else if (adv && last_s1) begin
				valid_s1 <= 1'b0;
			end else if (adv) begin
				idx_q <= idx_q + sfe_pkg::cnt_t'(1);
			end

			if (adv) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lst_s1 <= lst_c;
			cnt_s1 <= pos_c;
			end_s1 <= payload_end;
		end
		if (adv) begin
			frame_byte <= lst_s1[idx_q];
			run_last   <= last_s1;
			frame_done <= last_s1 && end_s1;
		end
	end

	// assertions
	`SFE_ASSERT_IMP(a_idx_in_range, valid_s1, idx_q < cnt_s1, "byte index past item length")
	`SFE_ASSERT_IMP(a_done_is_last, out_valid && frame_done, run_last,
		"closing flag not marked as last byte of its transaction")
	`SFE_ASSERT_IMP(a_done_is_flag, out_valid && frame_done, frame_byte == flag_q,
		"closing byte differs from flag value")
	`SFE_ASSERT_NXT(a_accept_loads, in_valid && !in_stall, valid_s1 && (idx_q == '0),
		"accepted transaction not loaded into item register")

endmodule

### tb/testbench.sv
// Testbench for the stuffed frame encoder: directed and random frames, self-checking.
`timescale 1ns / 1ps
module testbench;

	// One expected frame byte, as the output channel should present it.
	typedef struct {
		sfe_pkg::byte_t fbyte;
		logic           rlast;
		logic           fdone;
	} enc_byte_t;

	localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
	localparam int SETTLE_CYCLES  = 8;     // pipeline is two deep, this is plenty
	localparam int HOLD_CYCLES    = 150;   // long receiver hold-off

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	sfe_pkg::cfg_idx_t cfg_index;
	sfe_pkg::byte_t    cfg_data;
	logic              in_valid;
	logic              in_stall;
	sfe_pkg::byte_t    data_byte;
	logic              sequence_bit;
	logic              payload_start;
	logic              payload_end;
	logic              out_valid;
	logic              out_stall = 1'b0;
	sfe_pkg::byte_t    frame_byte;
	logic              run_last;
	logic              frame_done;

	stuffed_frame_encoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.sequence_bit (sequence_bit),
		.payload_start(payload_start),
		.payload_end  (payload_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.run_last     (run_last),
		.frame_done   (frame_done)
	);

	// Shadow copy of the register file and of the running block check.
	sfe_pkg::byte_t flag_cfg;
	sfe_pkg::byte_t esc_cfg;
	sfe_pkg::byte_t mask_cfg;
	sfe_pkg::byte_t addr_cfg;
	sfe_pkg::byte_t check_acc;

	// Frame bytes predicted but not yet seen on the output, oldest first.
	enc_byte_t pending_frame_bytes[$];

	// Idle controls; the two rates are in percent of cycles, hold_left counts down.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_left     = 0;

	int errors        = 0;
	int bytes_sent    = 0;
	int bytes_checked = 0;
	int frames_closed = 0;
	int reg_writes    = 0;
	int idle_count    = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// A byte that collides with flag or escape goes out as escape, byte & mask.
	// Flag equal to escape is a single test, so the byte is stuffed once.
	task automatic add_stuffed(input sfe_pkg::byte_t b, ref enc_byte_t seq_q[$]);
		if (b == flag_cfg || b == esc_cfg) begin
			seq_q.push_back('{esc_cfg, 1'b0, 1'b0});
			seq_q.push_back('{b & mask_cfg, 1'b0, 1'b0});
		end else begin
			seq_q.push_back('{b, 1'b0, 1'b0});
		end
	endtask

	// Expands one accepted payload byte into the frame bytes it must cause.
	task automatic encode_payload_byte(input sfe_pkg::byte_t d, input logic seq,
			input logic st, input logic en);
		enc_byte_t      seq_q[$];
		sfe_pkg::byte_t ctrl;
		ctrl = sfe_pkg::byte_t'(seq) << sfe_pkg::SEQ_SHIFT;
		// A start always opens a fresh header, even in the middle of a frame,
		// and clears the running check; the old frame is simply abandoned.
		if (st) begin
			seq_q.push_back('{flag_cfg, 1'b0, 1'b0});
			seq_q.push_back('{addr_cfg, 1'b0, 1'b0});
			seq_q.push_back('{ctrl, 1'b0, 1'b0});
			seq_q.push_back('{addr_cfg ^ ctrl, 1'b0, 1'b0});
			check_acc = '0;
		end
		// Bytes without a start are plain continuation bytes.
		check_acc = check_acc ^ d;
		add_stuffed(d, seq_q);
		// The end appends the stuffed check and a closing flag, then the
		// check returns to zero for whatever follows.
		if (en) begin
			add_stuffed(check_acc, seq_q);
			seq_q.push_back('{flag_cfg, 1'b0, 1'b1});
			check_acc = '0;
		end
		seq_q[seq_q.size()-1].rlast = 1'b1;
		foreach (seq_q[i])
			pending_frame_bytes.push_back(seq_q[i]);
	endtask

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Offers one payload byte and returns once the block has taken it.
	// Inputs move on the falling edge; valid stays up across back-to-back
	// transactions, so it is assigned once per step.
	task automatic send_byte(input sfe_pkg::byte_t d, input logic seq, input logic st,
			input logic en);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid      = 1'b1;
		data_byte     = d;
		sequence_bit  = seq;
		payload_start = st;
		payload_end   = en;
		do
			@(posedge clk);
		while (in_stall);
		encode_payload_byte(d, seq, st, en);
		bytes_sent++;
	endtask

	task automatic write_reg(input sfe_pkg::cfg_idx_t idx, input sfe_pkg::byte_t val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
		case (idx)
			sfe_pkg::CFG_FLAG:    flag_cfg = val;
			sfe_pkg::CFG_ESCAPE:  esc_cfg  = val;
			sfe_pkg::CFG_MASK:    mask_cfg = val;
			sfe_pkg::CFG_ADDRESS: addr_cfg = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	// Drops valid and waits until every predicted byte has come out; the
	// extra cycles make sure the block is idle before a register write.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_frame_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, plus a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		enc_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frame_bytes.size() == 0) begin
				errors++;
				$error("frame byte %02h with no byte expected", frame_byte);
			end else begin
				want = pending_frame_bytes.pop_front();
				bytes_checked++;
				if (frame_byte !== want.fbyte) begin
					errors++;
					$error("frame_byte: expected %02h, got %02h", want.fbyte, frame_byte);
				end
				if (run_last !== want.rlast) begin
					errors++;
					$error("run_last: expected %0b, got %0b", want.rlast, run_last);
				end
				if (frame_done !== want.fdone) begin
					errors++;
					$error("frame_done: expected %0b, got %0b", want.fdone, frame_done);
				end
				if (want.fdone)
					frames_closed++;
			end
		end
	end

	// Watchdog: a run that stops moving in both directions is hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_count = 0;
		end else begin
			idle_count++;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Data that hits flag and escape often, otherwise anything.
	function automatic sfe_pkg::byte_t pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return flag_cfg;
		else if (r < 30)
			return esc_cfg;
		else
			return sfe_pkg::byte_t'($urandom_range(255));
	endfunction

	function automatic sfe_pkg::byte_t pick_reg_value();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		else if (r == 1)
			return 8'hFF;
		else
			return sfe_pkg::byte_t'($urandom_range(255));
	endfunction

	// Reset values, one-byte frames, stuffed data and stuffed check,
	// continuation without start, restart inside a frame.
	task automatic test_reset_defaults();
		// one-byte frame whose data and check both equal the flag, sequence 1
		send_byte(8'h7E, 1'b1, 1'b1, 1'b1);
		// data at escape, both extremes, check ends up at 8'hFF
		send_byte(8'h7D, 1'b0, 1'b1, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		send_byte(8'h7D, 1'b1, 1'b0, 1'b1);
		// check lands on the escape value
		send_byte(8'h01, 1'b1, 1'b1, 1'b0);
		send_byte(8'h7C, 1'b0, 1'b0, 1'b1);
		// bytes with no start ahead of them, then an end without a header
		send_byte(8'h7E, 1'b0, 1'b0, 1'b0);
		send_byte(8'h55, 1'b1, 1'b0, 1'b1);
		// a start in the middle of a frame drops the old check
		send_byte(8'h10, 1'b0, 1'b1, 1'b0);
		send_byte(8'h20, 1'b1, 1'b1, 1'b0);
		send_byte(8'h30, 1'b0, 1'b0, 1'b1);
		// byte after the closing flag is a continuation again
		send_byte(8'hA5, 1'b1, 1'b0, 1'b0);
		send_byte(8'h5A, 1'b0, 1'b0, 1'b1);
		drain();
	endtask

	// Register extremes, and flag equal to escape.
	task automatic test_config_extremes();
		write_reg(sfe_pkg::CFG_FLAG, 8'h00);
		write_reg(sfe_pkg::CFG_ESCAPE, 8'hFF);
		write_reg(sfe_pkg::CFG_MASK, 8'h00);
		write_reg(sfe_pkg::CFG_ADDRESS, 8'hFF);
		send_byte(8'h00, 1'b1, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		send_byte(8'h80, 1'b1, 1'b0, 1'b0);
		send_byte(8'h7F, 1'b0, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
		drain();
		write_reg(sfe_pkg::CFG_FLAG, 8'hAA);
		write_reg(sfe_pkg::CFG_ESCAPE, 8'hAA);
		write_reg(sfe_pkg::CFG_MASK, 8'hFF);
		write_reg(sfe_pkg::CFG_ADDRESS, 8'h00);
		send_byte(8'hAA, 1'b0, 1'b1, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0, 1'b1);   // check comes out as the shared value
		send_byte(8'hAA, 1'b1, 1'b1, 1'b1);
		drain();
	endtask

	// New register set between phases; sometimes flag and escape coincide.
	task automatic randomize_registers();
		sfe_pkg::byte_t f;
		f = pick_reg_value();
		write_reg(sfe_pkg::CFG_FLAG, f);
		write_reg(sfe_pkg::CFG_ESCAPE, ($urandom_range(4) == 0) ? f : pick_reg_value());
		write_reg(sfe_pkg::CFG_MASK, pick_reg_value());
		write_reg(sfe_pkg::CFG_ADDRESS, pick_reg_value());
	endtask

	// Mostly complete frames with random content; some loose continuation
	// bytes and some frames cut short by a new start.
	task automatic test_random_frames(input int n_items);
		int sent;
		int len;
		int r;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 10) begin
				send_byte(pick_byte(), 1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)));
				sent++;
			end else begin
				len = ($urandom_range(9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 16);
				for (int i = 0; i < len; i++)
					// broken frames (r < 20) never send their end marker
					send_byte(pick_byte(), 1'($urandom_range(1)), (i == 0),
						(r >= 20) && (i == len - 1));
				sent += len;
			end
		end
		drain();
	endtask

	// Receiver holds off while the sender keeps offering a long frame, so the
	// block fills and has to stall its input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_left     = HOLD_CYCLES;
		for (int i = 0; i < 12; i++)
			send_byte(pick_byte(), 1'($urandom_range(1)), (i == 0), (i == 11));
		drain();
	endtask

	initial begin
		int send_pcts[4];
		int stall_pcts[4];
		send_pcts  = '{0, 70, 0, 13};
		stall_pcts = '{0, 0, 70, 13};

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = sfe_pkg::CFG_FLAG;
		cfg_data      = '0;
		in_valid      = 1'b0;
		data_byte     = '0;
		sequence_bit  = 1'b0;
		payload_start = 1'b0;
		payload_end   = 1'b0;
		flag_cfg      = sfe_pkg::FLAG_RST;
		esc_cfg       = sfe_pkg::ESCAPE_RST;
		mask_cfg      = sfe_pkg::MASK_RST;
		addr_cfg      = sfe_pkg::ADDRESS_RST;
		check_acc     = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_config_extremes();
		foreach (send_pcts[p]) begin
			send_idle_pct = send_pcts[p];
			stall_pct     = stall_pcts[p];
			randomize_registers();
			test_random_frames(100);
		end
		test_backpressure();

		// leftover expectations would mean lost bytes
		if (pending_frame_bytes.size() != 0) begin
			errors++;
			$error("%0d frame bytes never arrived", pending_frame_bytes.size());
		end
		$display("covered %0d payload bytes, %0d frame bytes, %0d closed frames,",
			bytes_sent, bytes_checked, frames_closed);
		$display("%0d register writes, four idle mixes and one long receiver hold-off",
			reg_writes);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/sfe_pkg.sv
rtl/stuffed_frame_encoder_core.sv
tb/testbench.sv
